/* src/deadline_timer_queue_core_defines.svh */
// Assertion macros shared by the deadline timer queue RTL.
`ifndef DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTQ_ASSERT_NOW(name, ck, rn, pre, post, msg) \
	name: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTQ_ASSERT_NEXT(name, ck, rn, pre, post, msg) \
	name: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
		else $error(msg);

`endif

/* src/dtq_pkg.sv */
// Shared types for the deadline timer queue.
`default_nettype none
package dtq_pkg;
	typedef struct packed {
		logic [31:0] deadline;
		logic [3:0]  thread;
	} key_t;

	typedef struct packed {
		logic [31:0] deadline;
		logic [3:0]  thread;
		logic [15:0] tag;
	} entry_t;

	typedef struct packed {
		logic eq;
		logic lt;
	} cmp_res_t;

	typedef enum logic [1:0] {
		RING_NOP,
		RING_READ,
		RING_WRITE,
		RING_POP
	} ring_op_t;
endpackage
`default_nettype wire

/* src/dtq_cmp.sv */
// Shared key comparator: orders two keys by deadline and then by thread.
`default_nettype none
module dtq_cmp import dtq_pkg::*; (
	input  key_t     a,
	input  key_t     b,
	output cmp_res_t res
);
	logic dl_eq;
	logic dl_lt;

	assign dl_eq  = (a.deadline == b.deadline);
	assign dl_lt  = (a.deadline < b.deadline);
	assign res.eq = dl_eq && (a.thread == b.thread);
	assign res.lt = dl_lt || (dl_eq && (a.thread < b.thread));
endmodule
`default_nettype wire

/* src/dtq_ring.sv */
// Circular entry memory addressed by position from the queue head.
`default_nettype none
module dtq_ring import dtq_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int TAG_W = 16,
	localparam int IdxW = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ring_op_t        op,
	input  logic [IdxW-1:0] idx,
	input  entry_t          wdata,
	output entry_t          rdata
);
	logic [31:0]      dl_mem  [DEPTH];
	logic [3:0]       thr_mem [DEPTH];
	logic [TAG_W-1:0] tag_mem [DEPTH];
	logic [IdxW-1:0]  head_q;
	logic [IdxW:0]    sum;
	logic [IdxW:0]    wrapped;
	logic [IdxW-1:0]  phys;
	entry_t           rdata_q;

	always_comb begin
		sum = {1'b0, head_q} + {1'b0, idx};
		if (sum >= (IdxW+1)'(DEPTH)) begin
			wrapped = sum - (IdxW+1)'(DEPTH);
		end else begin
			wrapped = sum;
		end
		phys = wrapped[IdxW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (op == RING_POP) begin
			if (head_q == IdxW'(DEPTH - 1)) begin
				head_q <= '0;
			end else begin
				head_q <= head_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op == RING_WRITE) begin
			dl_mem[phys]  <= wdata.deadline;
			thr_mem[phys] <= wdata.thread;
			tag_mem[phys] <= wdata.tag[TAG_W-1:0];
		end
		if (op == RING_READ) begin
			rdata_q.deadline <= dl_mem[phys];
			rdata_q.thread   <= thr_mem[phys];
			rdata_q.tag      <= 16'(tag_mem[phys]);
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

/* src/deadline_timer_queue_core.sv */
// Top level of the deadline timer queue: sequencer, latest-deadline table and result register.
// The queue keeps timer entries sorted by deadline and thread in a single-port circular
// memory and walks it one entry at a time with a single shared key comparator, so the input
// is not ready while an item is in progress. An enqueue reads and compares the entries from
// the head until its place is found, moves each later entry back by one to open that place,
// and writes the new entry there; a check reads the head and pops it, waking its thread
// unless it is stale, until the queue empties or a later head ends the walk. Either may also
// wait for the result channel to be free, and the input is ready again in the cycle after
// the final result is loaded. Each memory read is registered. The per-thread latest-deadline
// table is cleared at reset through per-thread valid bits, so no clearing pass is needed.
// The final result of an item may still wait in the output register while the next item
// is accepted.
`default_nettype none
`include "deadline_timer_queue_core_defines.svh"
module deadline_timer_queue_core import dtq_pkg::*; #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int THREAD_COUNT = 16,
	parameter int TAG_BITS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// thread_id[3:0], wake_tag[19:4], deadline[51:20], now[83:52], zero pad
	input  logic [87:0] s_tdata,
	// mode[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// woken_thread[3:0], woken_tag[19:4], next_deadline[51:20], status[53:52], zero pad
	output logic [55:0] m_tdata,
	// kind[1:0]
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);
	localparam int IdxW = $clog2(QUEUE_DEPTH);
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);
	localparam int LatW = $clog2(THREAD_COUNT);
	localparam int TagW = (TAG_BITS < 16) ? TAG_BITS : 16;

	localparam logic [1:0] KIND_WAKE = 2'd0;
	localparam logic [1:0] KIND_ACK  = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_DUP  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_CMP,
		S_DECIDE,
		S_SHIFT,
		S_SHIFT_WR,
		S_PUT,
		S_ACK,
		S_CHK_HEAD,
		S_CHK_LATRD,
		S_CHK_LAT,
		S_CHK_DL,
		S_WAKE,
		S_POP,
		S_FIN
	} state_t;

	function automatic logic [LatW-1:0] thr_index(input logic [3:0] thr);
		logic [8:0] v;
		v = 9'(thr);
		for (int k = 0; k < 8; k++) begin
			if (v >= 9'(THREAD_COUNT)) begin
				v = v - 9'(THREAD_COUNT);
			end
		end
		return v[LatW-1:0];
	endfunction

	state_t          state_q;
	logic [3:0]      thr_q;
	logic [15:0]     tag_q;
	logic [31:0]     dl_q;
	logic [31:0]     now_q;
	logic [CntW-1:0] cnt_q;
	logic [CntW-1:0] idx_q;
	logic [CntW-1:0] pos_q;
	logic [1:0]      stat_q;
	logic [31:0]     upcoming_q;

	logic            out_vld_q;
	logic [1:0]      out_kind_q;
	logic [3:0]      out_thr_q;
	logic [15:0]     out_tag_q;
	logic [31:0]     out_next_q;
	logic [1:0]      out_stat_q;
	logic            out_last_q;

	logic [31:0]             lat_mem [THREAD_COUNT];
	logic [THREAD_COUNT-1:0] lat_vld_q;
	logic [31:0]             lat_rd_q;
	logic                    lat_rd_vld_q;
	logic [31:0]             lat_value;
	logic                    lat_we;
	logic [LatW-1:0]         lat_wa;
	logic [LatW-1:0]         lat_ra;

	ring_op_t        ring_op;
	logic [CntW-1:0] ring_idx;
	entry_t          ring_wdata;
	entry_t          ring_rdata;
	key_t            cmp_a;
	key_t            cmp_b;
	cmp_res_t        cmp;
	logic            out_free;
	logic            out_load;
	logic            full;
	logic [15:0]     tag_in;

	assign s_tready  = (state_q == S_IDLE);
	assign out_free  = !out_vld_q || m_tready;
	assign out_load  = out_free &&
		(state_q == S_ACK || state_q == S_WAKE || state_q == S_FIN);
	assign full      = (cnt_q == CntW'(QUEUE_DEPTH));
	assign tag_in    = 16'(s_tdata[4 +: TagW]);
	assign lat_value = lat_rd_vld_q ? lat_rd_q : '0;
	assign lat_wa    = thr_index(thr_q);
	assign lat_ra    = thr_index(ring_rdata.thread);
	assign lat_we    = (state_q == S_SCAN_CMP && cmp.eq) || (state_q == S_DECIDE && !full);

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, out_stat_q, out_next_q, out_tag_q, out_thr_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	always_comb begin
		ring_op    = RING_NOP;
		ring_idx   = idx_q;
		ring_wdata = ring_rdata;
		case (state_q)
			S_SCAN: begin
				if (idx_q != cnt_q) begin
					ring_op = RING_READ;
				end
			end
			S_SHIFT: begin
				ring_idx = idx_q - 1'b1;
				if (idx_q != pos_q) begin
					ring_op = RING_READ;
				end
			end
			S_SHIFT_WR: begin
				ring_op = RING_WRITE;
			end
			S_PUT: begin
				ring_op    = RING_WRITE;
				ring_idx   = pos_q;
				ring_wdata = '{deadline: dl_q, thread: thr_q, tag: tag_q};
			end
			S_CHK_HEAD: begin
				ring_idx = '0;
				if (cnt_q != '0) begin
					ring_op = RING_READ;
				end
			end
			S_POP: begin
				ring_op = RING_POP;
			end
			default: begin
				ring_op = RING_NOP;
			end
		endcase
	end

	always_comb begin
		cmp_a = '0;
		cmp_b = '0;
		case (state_q)
			S_SCAN_CMP: begin
				cmp_a = '{deadline: ring_rdata.deadline, thread: ring_rdata.thread};
				cmp_b = '{deadline: dl_q, thread: thr_q};
			end
			S_CHK_LAT: begin
				cmp_a.deadline = now_q;
				cmp_b.deadline = lat_value;
			end
			S_CHK_DL: begin
				cmp_a.deadline = now_q;
				cmp_b.deadline = ring_rdata.deadline;
			end
			default: begin
				cmp_a = '0;
			end
		endcase
	end

	dtq_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp)
	);

	dtq_ring #(
		.DEPTH (QUEUE_DEPTH),
		.TAG_W (TagW)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (ring_op),
		.idx    (ring_idx[IdxW-1:0]),
		.wdata  (ring_wdata),
		.rdata  (ring_rdata)
	);

	always_ff @(posedge clk) begin
		if (lat_we) begin
			lat_mem[lat_wa] <= dl_q;
		end
		lat_rd_q <= lat_mem[lat_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_vld_q    <= '0;
			lat_rd_vld_q <= 1'b0;
		end else begin
			if (lat_we) begin
				lat_vld_q[lat_wa] <= 1'b1;
			end
			lat_rd_vld_q <= lat_vld_q[lat_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			thr_q      <= '0;
			tag_q      <= '0;
			dl_q       <= '0;
			now_q      <= '0;
			cnt_q      <= '0;
			idx_q      <= '0;
			pos_q      <= '0;
			stat_q     <= STAT_OK;
			upcoming_q <= '0;
			out_vld_q  <= 1'b0;
			out_kind_q <= KIND_WAKE;
			out_thr_q  <= '0;
			out_tag_q  <= '0;
			out_next_q <= '0;
			out_stat_q <= STAT_OK;
			out_last_q <= 1'b0;
		end else begin
			if (out_vld_q && m_tready && !out_load) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						thr_q <= s_tdata[3:0];
						tag_q <= tag_in;
						dl_q  <= s_tdata[51:20];
						now_q <= s_tdata[83:52];
						idx_q <= '0;
						if (s_tuser[0]) begin
							upcoming_q <= s_tdata[83:52];
							state_q    <= S_CHK_HEAD;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (idx_q == cnt_q) begin
						pos_q   <= idx_q;
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_SCAN_CMP;
					end
				end
				S_SCAN_CMP: begin
					if (cmp.eq) begin
						stat_q  <= STAT_DUP;
						state_q <= S_ACK;
					end else if (!cmp.lt) begin
						pos_q   <= idx_q;
						state_q <= S_DECIDE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_DECIDE: begin
					if (full) begin
						stat_q  <= STAT_FULL;
						state_q <= S_ACK;
					end else begin
						idx_q   <= cnt_q;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (idx_q == pos_q) begin
						state_q <= S_PUT;
					end else begin
						state_q <= S_SHIFT_WR;
					end
				end
				S_SHIFT_WR: begin
					idx_q   <= idx_q - 1'b1;
					state_q <= S_SHIFT;
				end
				S_PUT: begin
					cnt_q   <= cnt_q + 1'b1;
					stat_q  <= STAT_OK;
					state_q <= S_ACK;
				end
				S_ACK: begin
					if (out_load) begin
						out_vld_q  <= 1'b1;
						out_kind_q <= KIND_ACK;
						out_thr_q  <= '0;
						out_tag_q  <= '0;
						out_next_q <= '0;
						out_stat_q <= stat_q;
						out_last_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_CHK_HEAD: begin
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_CHK_LATRD;
					end
				end
				S_CHK_LATRD: begin
					state_q <= S_CHK_LAT;
				end
				S_CHK_LAT: begin
					if (!cmp.lt) begin
						state_q <= S_WAKE;
					end else begin
						state_q <= S_CHK_DL;
					end
				end
				S_CHK_DL: begin
					if (cmp.lt) begin
						upcoming_q <= ring_rdata.deadline;
						state_q    <= S_FIN;
					end else begin
						state_q <= S_POP;
					end
				end
				S_WAKE: begin
					if (out_load) begin
						out_vld_q  <= 1'b1;
						out_kind_q <= KIND_WAKE;
						out_thr_q  <= ring_rdata.thread;
						out_tag_q  <= ring_rdata.tag;
						out_next_q <= '0;
						out_stat_q <= STAT_OK;
						out_last_q <= 1'b0;
						state_q    <= S_POP;
					end
				end
				S_POP: begin
					cnt_q   <= cnt_q - 1'b1;
					state_q <= S_CHK_HEAD;
				end
				S_FIN: begin
					if (out_load) begin
						out_vld_q  <= 1'b1;
						out_kind_q <= KIND_DONE;
						out_thr_q  <= '0;
						out_tag_q  <= '0;
						out_next_q <= upcoming_q;
						out_stat_q <= STAT_OK;
						out_last_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`DTQ_ASSERT_NOW(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CntW'(QUEUE_DEPTH), "Entry count exceeds depth")
	`DTQ_ASSERT_NOW(a_pop_nonempty, clk, arst_n, state_q == S_POP, cnt_q != '0, "Pop from empty queue")
	`DTQ_ASSERT_NEXT(a_put_grows, clk, arst_n, state_q == S_PUT, cnt_q == $past(cnt_q) + 1'b1, "Insert did not grow queue")
	`DTQ_ASSERT_NOW(a_shift_cursor, clk, arst_n, state_q == S_SHIFT_WR, idx_q > pos_q, "Shift moved past insert slot")
endmodule
`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the deadline timer queue core.
`timescale 1ns / 1ps

module tb;
	import dtq_pkg::*;

	localparam int DEPTH = 16;
	localparam int THREADS = 16;

	localparam logic MODE_ENQUEUE = 1'b0;
	localparam logic MODE_CHECK   = 1'b1;

	localparam logic [1:0] EV_WAKE = 2'd0;
	localparam logic [1:0] EV_ACK  = 2'd1;
	localparam logic [1:0] EV_DONE = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_DUP  = 2'd2;

	typedef struct {
		logic        mode;
		logic [3:0]  thread;
		logic [15:0] tag;
		logic [31:0] deadline;
		logic [31:0] now;
	} timer_req_t;

	typedef struct {
		logic [1:0]  kind;
		logic [3:0]  thread;
		logic [15:0] tag;
		logic [31:0] next_dl;
		logic [1:0]  status;
		logic        last;
	} timer_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	deadline_timer_queue_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	timer_req_t   request_queue[$];
	timer_event_t expected_events[$];
	timer_req_t   offered_req;

	logic [31:0] q_deadline[DEPTH];
	logic [3:0]  q_thread[DEPTH];
	logic [15:0] q_tag[DEPTH];
	int          q_count = 0;
	logic [31:0] latest_deadline[THREADS];
	logic [31:0] upcoming_time = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int long_stall_req = 0;
	int long_stall_seen = 0;
	int long_stall_left = 0;
	int error_count = 0;
	int n_enqueue = 0, n_check = 0, n_wake = 0, n_stale = 0, n_full = 0, n_dup = 0;
	int n_results = 0;

	logic [31:0] base_time;
	logic [3:0]  prev_thread = '0;
	logic [31:0] prev_deadline = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("Timeout with %0d results still expected.", expected_events.size());
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic void push_event(logic [1:0] kind, logic [3:0] thr, logic [15:0] tag,
			logic [31:0] next_dl, logic [1:0] status, logic last);
		timer_event_t ev;
		ev.kind = kind;
		ev.thread = thr;
		ev.tag = tag;
		ev.next_dl = next_dl;
		ev.status = status;
		ev.last = last;
		expected_events.push_back(ev);
	endfunction

	function automatic void pop_queue_head();
		for (int i = 1; i < q_count; i++) begin
			q_deadline[i - 1] = q_deadline[i];
			q_thread[i - 1] = q_thread[i];
			q_tag[i - 1] = q_tag[i];
		end
		q_count--;
	endfunction

	function automatic void apply_timer_request(timer_req_t r);
		int pos;
		logic [3:0] ht;
		bit stop;
		if (r.mode == MODE_ENQUEUE) begin
			n_enqueue++;
			for (int i = 0; i < q_count; i++) begin
				if (q_deadline[i] == r.deadline && q_thread[i] == r.thread) begin
					latest_deadline[r.thread] = r.deadline;
					n_dup++;
					push_event(EV_ACK, '0, '0, '0, ST_DUP, 1'b1);
					return;
				end
			end
			if (q_count >= DEPTH) begin
				n_full++;
				push_event(EV_ACK, '0, '0, '0, ST_FULL, 1'b1);
				return;
			end
			latest_deadline[r.thread] = r.deadline;
			pos = 0;
			while (pos < q_count && (q_deadline[pos] < r.deadline ||
					(q_deadline[pos] == r.deadline && q_thread[pos] < r.thread)))
				pos++;
			for (int i = q_count; i > pos; i--) begin
				q_deadline[i] = q_deadline[i - 1];
				q_thread[i] = q_thread[i - 1];
				q_tag[i] = q_tag[i - 1];
			end
			q_deadline[pos] = r.deadline;
			q_thread[pos] = r.thread;
			q_tag[pos] = r.tag;
			q_count++;
			push_event(EV_ACK, '0, '0, '0, ST_OK, 1'b1);
		end else begin
			n_check++;
			upcoming_time = r.now;
			stop = 1'b0;
			while (q_count > 0 && !stop) begin
				ht = q_thread[0];
				if (r.now >= latest_deadline[ht]) begin
					n_wake++;
					push_event(EV_WAKE, ht, q_tag[0], '0, ST_OK, 1'b0);
					pop_queue_head();
				end else if (r.now < q_deadline[0]) begin
					upcoming_time = q_deadline[0];
					stop = 1'b1;
				end else begin
					n_stale++;
					pop_queue_head();
				end
			end
			push_event(EV_DONE, '0, '0, upcoming_time, ST_OK, 1'b1);
		end
	endfunction

	// Sender: holds each request until it is taken, then offers the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready)
				apply_timer_request(offered_req);
			if (!s_tvalid || s_tready) begin
				if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered_req = request_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, offered_req.now, offered_req.deadline,
						offered_req.tag, offered_req.thread};
					s_tuser <= offered_req.mode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when one is requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (long_stall_seen != long_stall_req) begin
			long_stall_seen = long_stall_req;
			long_stall_left = 400;
			m_tready <= 1'b0;
		end else if (long_stall_left > 0) begin
			long_stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic note_mismatch(string what, logic [31:0] exp_val, logic [31:0] act_val);
		error_count++;
		if (error_count <= 40)
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_val, act_val);
	endtask

	always @(posedge clk) begin
		timer_event_t ev;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			n_results++;
			if (expected_events.size() == 0) begin
				error_count++;
				if (error_count <= 40)
					$display("%0t: expected no result, got kind %0h data %0h last %0b",
						$time, m_tuser, m_tdata, m_tlast);
			end else begin
				ev = expected_events.pop_front();
				if (m_tuser !== ev.kind)
					note_mismatch("kind", 32'(ev.kind), 32'(m_tuser));
				if (m_tdata[3:0] !== ev.thread)
					note_mismatch("woken_thread", 32'(ev.thread), 32'(m_tdata[3:0]));
				if (m_tdata[19:4] !== ev.tag)
					note_mismatch("woken_tag", 32'(ev.tag), 32'(m_tdata[19:4]));
				if (m_tdata[51:20] !== ev.next_dl)
					note_mismatch("next_deadline", ev.next_dl, m_tdata[51:20]);
				if (m_tdata[53:52] !== ev.status)
					note_mismatch("status", 32'(ev.status), 32'(m_tdata[53:52]));
				if (m_tlast !== ev.last)
					note_mismatch("last", 32'(ev.last), 32'(m_tlast));
			end
		end
	end

	task automatic add_enqueue(logic [3:0] thr, logic [15:0] tag, logic [31:0] dl);
		timer_req_t r;
		r.mode = MODE_ENQUEUE;
		r.thread = thr;
		r.tag = tag;
		r.deadline = dl;
		r.now = $urandom;
		request_queue.push_back(r);
	endtask

	task automatic add_check(logic [31:0] now);
		timer_req_t r;
		r.mode = MODE_CHECK;
		r.thread = 4'($urandom_range(15));
		r.tag = 16'($urandom);
		r.deadline = $urandom;
		r.now = now;
		request_queue.push_back(r);
	endtask

	task automatic wait_for_drain();
		while (request_queue.size() != 0 || s_tvalid || expected_events.size() != 0)
			@(negedge clk);
	endtask

	// Mostly bursts of enqueues near a moving time base followed by checks; the rest
	// is fully random noise.
	task automatic add_random_requests(int count);
		int made;
		int burst;
		timer_req_t r;
		made = 0;
		while (made < count) begin
			if ($urandom_range(99) < 75) begin
				burst = $urandom_range(1, 20);
				for (int k = 0; k < burst; k++) begin
					if ($urandom_range(9) == 0) begin
						add_enqueue(prev_thread, 16'($urandom), prev_deadline);
					end else begin
						prev_thread = 4'($urandom_range(15));
						prev_deadline = base_time + $urandom_range(1, 120);
						add_enqueue(prev_thread, 16'($urandom), prev_deadline);
					end
				end
				made += burst;
				for (int k = $urandom_range(1, 3); k > 0; k--) begin
					base_time = base_time + $urandom_range(0, 90);
					add_check(base_time);
					made++;
				end
				if ($urandom_range(7) == 0) begin
					add_check(32'hFFFF_FFFF);
					base_time = $urandom_range(32'hFFFF_0000, 0);
					made++;
				end
			end else begin
				r.mode = 1'($urandom_range(1));
				r.thread = 4'($urandom_range(15));
				r.tag = 16'($urandom);
				r.deadline = $urandom;
				r.now = $urandom;
				request_queue.push_back(r);
				made++;
			end
		end
	endtask

	initial begin
		for (int i = 0; i < THREADS; i++)
			latest_deadline[i] = '0;
		base_time = $urandom_range(32'hFFFF_0000, 0);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty check, then a full queue with re-enqueued, stale and duplicate entries.
		add_check(32'd0);
		add_enqueue(4'd0, 16'h0000, 32'd0);
		add_enqueue(4'd15, 16'hFFFF, 32'hFFFF_FFFF);
		add_enqueue(4'd3, 16'h1234, 32'd100);
		add_enqueue(4'd3, 16'h4321, 32'd50);
		add_enqueue(4'd5, 16'hA5A5, 32'd100);
		add_enqueue(4'd5, 16'h5A5A, 32'd200);
		for (int i = 1; i <= 10; i++)
			add_enqueue(i[3:0], 16'($urandom), 32'd1000 + i);
		add_enqueue(4'd0, 16'hBEEF, 32'd0);
		add_enqueue(4'd7, 16'h0F0F, 32'd5);
		add_check(32'd60);
		add_check(32'd150);
		add_check(32'hFFFF_FFFF);
		wait_for_drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 79;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 79;
				end
				default: begin
					send_idle_pct = 22;
					recv_stall_pct = 22;
				end
			endcase
			add_random_requests(80);
			if (phase == 0) begin
				repeat (20) @(negedge clk);
				long_stall_req++;
			end
			wait_for_drain();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (100) @(negedge clk);

		$display("Ran %0d requests: %0d enqueues and %0d checks, with %0d results seen.",
			n_enqueue + n_check, n_enqueue, n_check, n_results);
		$display("Saw %0d wakes, %0d stale discards, %0d full drops, %0d duplicate drops.",
			n_wake, n_stale, n_full, n_dup);
		if (error_count == 0 && expected_events.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
